FILE: hdl/spq_pkg.sv
// Shared types, codes and defaults of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // One stored process entry.
    typedef struct packed {
        logic        [15:0] id;
        logic signed [15:0] prio;
        logic        [15:0] run;
        logic        [15:0] arr;
    } t_entry;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic        ins;
        logic        del;
        t_entry      new_entry;
    } t_cell_ctl;

    // Signals one cell hands to its neighbors.
    typedef struct packed {
        logic        take;
        logic        seen;
        t_entry      entry;
    } t_link;

endpackage

FILE: hdl/spq_cell.sv
// One compare-and-shift cell of the sorted priority queue.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_link     i_left,
    input  t_entry    i_right_entry,
    output t_link     o_link,
    output t_entry    o_next
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_take;
    logic   w_seen;

    // The new entry belongs here or further left when this slot is empty or
    // holds a priority no higher than the new one.
    assign w_take = !i_valid || (i_ctl.new_entry.prio >= r_entry.prio);
    assign w_seen = i_left.seen || (i_valid && (r_entry.id == i_ctl.new_entry.id));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && w_take) begin
            n_entry = i_left.take ? i_left.entry : i_ctl.new_entry;
        end else if (i_ctl.del && w_seen) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.take  = w_take;
    assign o_link.seen  = w_seen;
    assign o_link.entry = r_entry;
    assign o_next       = n_entry;

endmodule

FILE: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of compare-and-shift cells.
//
// Usage: drive i_command and the entry fields and raise start for one cycle
// per command. A command beat is taken at each rising edge where start is
// high and busy is low. busy stays low, so a command may be issued in every
// cycle, back to back.
// Each command produces one result beat on the cycle after it is taken:
// o_done is high for exactly that cycle, and o_status, the head entry fields
// and o_occupancy are valid alongside it. The throughput is one command per
// cycle; the whole insert or delete happens at the clock edge that takes the
// command, with the id match signal rippling combinationally along the row
// of DEPTH cells.
// An insert finds its slot through each cell comparing its own priority with
// the new one; cells at and behind that slot shift one place toward the
// tail. A delete lets every cell at and behind the first id match pull in
// its right neighbor. A full queue drops inserts with a full status.
// The receiver cannot stall: a result is shown for one cycle only.
// Reset (i_rst_n low at a clock edge) empties the queue and clears o_done;
// the entry storage itself is not cleared, only the fill count.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic        [15:0] i_entry_id,
    input  logic signed [15:0] i_priority_req,
    input  logic        [15:0] i_run_time,
    input  logic        [15:0] i_arrival_time,
    output logic               o_done,
    output logic        [1:0]  o_status,
    output logic               o_head_valid,
    output logic        [15:0] o_head_id,
    output logic signed [15:0] o_head_priority,
    output logic        [15:0] o_head_run_time,
    output logic        [15:0] o_head_arrival_time,
    output logic        [4:0]  o_occupancy
);

    localparam int FillW = $clog2(DEPTH + 1);

    logic [FillW-1:0] r_fill;
    logic [FillW-1:0] n_fill;
    logic             r_done;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    t_entry           r_head;
    t_entry           n_head;

    t_cell_ctl w_ctl;
    t_link     w_link [DEPTH];
    t_entry    w_next [DEPTH];
    logic      w_accept;
    logic      w_full;
    logic      w_found;

    // Every command is taken in the cycle it is offered.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_fill == FillW'(DEPTH));
    assign w_found  = w_link[DEPTH-1].seen;

    always_comb begin
        w_ctl.new_entry.id   = i_entry_id;
        w_ctl.new_entry.prio = i_priority_req;
        w_ctl.new_entry.run  = i_run_time;
        w_ctl.new_entry.arr  = i_arrival_time;
        w_ctl.ins = w_accept && (i_command == CMD_INSERT) && !w_full;
        w_ctl.del = w_accept && (i_command == CMD_DELETE);
    end

    // The row of cells. Cell zero is the head; a cell's left neighbor sits
    // closer to the head.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_link  w_left;
        t_entry w_right;

        if (gi == 0) begin : g_head
            always_comb begin
                w_left.take  = 1'b0;
                w_left.seen  = 1'b0;
                w_left.entry = '0;
            end
        end else begin : g_body
            assign w_left = w_link[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_link[gi+1].entry;
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_valid       (FillW'(gi) < r_fill),
            .i_left        (w_left),
            .i_right_entry (w_right),
            .o_link        (w_link[gi]),
            .o_next        (w_next[gi])
        );
    end

    // Status, the new fill count and the new head entry.
    always_comb begin
        n_fill   = r_fill;
        n_status = ST_OK;
        if (i_command == CMD_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_fill = r_fill + FillW'(1);
            end
        end else begin
            if (r_fill == '0) begin
                n_status = ST_EMPTY;
            end else if (!w_found) begin
                n_status = ST_NOT_FOUND;
            end else begin
                n_fill = r_fill - FillW'(1);
            end
        end
        n_head = (n_fill != '0) ? w_next[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_fill <= n_fill;
            end
        end
    end

    // Result fields are held in registers shown with the done strobe.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_head   <= n_head;
        end
    end

    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_head_valid        = (r_fill != '0);
    assign o_head_id           = r_head.id;
    assign o_head_priority     = r_head.prio;
    assign o_head_run_time     = r_head.run;
    assign o_head_arrival_time = r_head.arr;
    assign o_occupancy         = 5'(r_fill);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillW'(DEPTH))
        else $error("fill count exceeds the queue depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("command taken without a result beat");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_FULL) |-> r_fill == FillW'(DEPTH))
        else $error("full status reported on a queue that is not full");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_fill))
        else $error("fill count changed without a command");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_fill > FillW'(1)) |-> w_link[0].entry.prio >= w_link[1].entry.prio)
        else $error("head entry is out of priority order");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sorted priority queue: directed table, then random commands.
module tb
    import spq_pkg::*;
();

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int N_RANDOM   = 1025;
    localparam int N_DIRECTED = 25;

    // One row of the directed table. When typed is set, the status and the
    // occupancy written in the row are the expectation for that beat.
    typedef struct packed {
        logic               cmd;
        logic        [15:0] id;
        logic signed [15:0] prio;
        logic        [15:0] run;
        logic        [15:0] arr;
        logic               typed;
        logic        [1:0]  status;
        logic        [4:0]  occ;
    } t_cmd_row;

    // Everything one result beat carries.
    typedef struct packed {
        logic [1:0] status;
        logic       head_valid;
        t_entry     head;
        logic [4:0] occ;
    } t_queue_view;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_command;
    logic        [15:0] i_entry_id;
    logic signed [15:0] i_priority_req;
    logic        [15:0] i_run_time;
    logic        [15:0] i_arrival_time;
    logic               o_done;
    logic        [1:0]  o_status;
    logic               o_head_valid;
    logic        [15:0] o_head_id;
    logic signed [15:0] o_head_priority;
    logic        [15:0] o_head_run_time;
    logic        [15:0] o_head_arrival_time;
    logic        [4:0]  o_occupancy;

    // Typed expectation that travels with the beat currently driven.
    logic               row_typed;
    logic        [1:0]  row_status;
    logic        [4:0]  row_occ;

    // Shadow copy of the queue contents, kept in the same sorted order.
    t_entry             shadow_store [DEPTH];
    int                 shadow_count = 0;
    t_queue_view        pending_views [$];
    int                 errors = 0;

    sorted_priority_queue #(.DEPTH(DEPTH)) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_command           (i_command),
        .i_entry_id          (i_entry_id),
        .i_priority_req      (i_priority_req),
        .i_run_time          (i_run_time),
        .i_arrival_time      (i_arrival_time),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_head_valid        (o_head_valid),
        .o_head_id           (o_head_id),
        .o_head_priority     (o_head_priority),
        .o_head_run_time     (o_head_run_time),
        .o_head_arrival_time (o_head_arrival_time),
        .o_occupancy         (o_occupancy)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Directed table. It opens with a delete on an empty queue, then
    // inserts the priority extremes with all-ones and all-zeros payloads,
    // two equal priorities so the newer one must land in front, a delete of
    // an absent id, a delete of the head, a fill up to the last slot, an
    // insert into the full queue, a delete of the tail, and finally a
    // duplicate id where only the entry nearest the head may go first.
    t_cmd_row cmd_table [N_DIRECTED] = '{
        '{CMD_DELETE, 16'h0000, 16'sh0000, 16'h0000, 16'h0000, 1'b1, ST_EMPTY,     5'd0},
        '{CMD_INSERT, 16'hFFFF, 16'sh8000, 16'hFFFF, 16'hFFFF, 1'b1, ST_OK,        5'd1},
        '{CMD_INSERT, 16'h0000, 16'sh7FFF, 16'h0000, 16'h0000, 1'b1, ST_OK,        5'd2},
        '{CMD_INSERT, 16'h0001, 16'sh0000, 16'h1234, 16'h0001, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0002, 16'sh0000, 16'h5678, 16'h0002, 1'b0, ST_OK,        5'd0},
        '{CMD_DELETE, 16'h04D2, 16'shAAAA, 16'h5555, 16'hAAAA, 1'b1, ST_NOT_FOUND, 5'd4},
        '{CMD_DELETE, 16'h0000, 16'sh5555, 16'hAAAA, 16'h5555, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0003, 16'sh0010, 16'h0003, 16'h0030, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0004, 16'shFFF0, 16'h0004, 16'h0040, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0005, 16'sh7FFF, 16'h0005, 16'h0050, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0006, 16'sh8000, 16'h0006, 16'h0060, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0007, 16'sh0001, 16'h0007, 16'h0070, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0008, 16'shFFFF, 16'h0008, 16'h0080, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h0009, 16'sh0000, 16'h0009, 16'h0090, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h000A, 16'sh4000, 16'h000A, 16'h00A0, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h000B, 16'shC000, 16'h000B, 16'h00B0, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h000C, 16'sh0010, 16'h000C, 16'h00C0, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h000D, 16'sh0002, 16'h000D, 16'h00D0, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h000E, 16'sh8001, 16'h000E, 16'h00E0, 1'b0, ST_OK,        5'd0},
        '{CMD_INSERT, 16'h000F, 16'sh7FFE, 16'h000F, 16'h00F0, 1'b1, ST_OK,        5'd16},
        '{CMD_INSERT, 16'h0010, 16'sh7FFF, 16'h0010, 16'h0100, 1'b1, ST_FULL,      5'd16},
        '{CMD_DELETE, 16'hFFFF, 16'sh0000, 16'h0000, 16'h0000, 1'b1, ST_OK,        5'd15},
        '{CMD_INSERT, 16'h0002, 16'sh0005, 16'hBEEF, 16'hCAFE, 1'b0, ST_OK,        5'd0},
        '{CMD_DELETE, 16'h0002, 16'sh0000, 16'h0000, 16'h0000, 1'b0, ST_OK,        5'd0},
        '{CMD_DELETE, 16'h0002, 16'sh0000, 16'h0000, 16'h0000, 1'b0, ST_OK,        5'd0}
    };

    // Applies one accepted command to the shadow queue and returns the view
    // of the queue that the block must report for it. An insert goes in
    // front of the first entry whose priority is not above its own, so the
    // newest of equal priorities ends up first. A delete takes out the
    // match nearest the head and closes the gap.
    function automatic t_queue_view apply_command(input logic cmd, input t_entry item);
        t_queue_view view;
        int          pos;
        int          k;
        logic        found;
        view   = '0;
        found  = 1'b0;
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= DEPTH) begin
                view.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && item.prio < shadow_store[pos].prio)
                    pos++;
                for (k = shadow_count; k > pos; k--)
                    shadow_store[k] = shadow_store[k - 1];
                shadow_store[pos] = item;
                shadow_count++;
                view.status = ST_OK;
            end
        end else if (shadow_count == 0) begin
            view.status = ST_EMPTY;
        end else begin
            view.status = ST_NOT_FOUND;
            for (pos = 0; pos < shadow_count && !found; pos++) begin
                if (shadow_store[pos].id == item.id) begin
                    found = 1'b1;
                    for (k = pos; k + 1 < shadow_count; k++)
                        shadow_store[k] = shadow_store[k + 1];
                    shadow_count--;
                    view.status = ST_OK;
                end
            end
        end
        if (shadow_count > 0) begin
            view.head_valid = 1'b1;
            view.head       = shadow_store[0];
        end
        view.occ = shadow_count[4:0];
        return view;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result side. Outputs are sampled at the rising edge, before the block
    // updates them, so the beat checked here belongs to a command taken at
    // an earlier edge. A command taken at this edge is predicted afterwards.
    always @(posedge i_clk) begin
        t_queue_view want;
        t_entry      item;
        if (o_done) begin
            if (pending_views.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with no command waiting for it", $time);
            end else begin
                want = pending_views.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("head_valid", 16'(want.head_valid), 16'(o_head_valid));
                check_field("head_id", want.head.id, o_head_id);
                check_field("head_priority", want.head.prio, o_head_priority);
                check_field("head_run_time", want.head.run, o_head_run_time);
                check_field("head_arrival_time", want.head.arr, o_head_arrival_time);
                check_field("occupancy", 16'(want.occ), 16'(o_occupancy));
            end
        end
        if (i_rst_n && start && !busy) begin
            item.id   = i_entry_id;
            item.prio = i_priority_req;
            item.run  = i_run_time;
            item.arr  = i_arrival_time;
            want = apply_command(i_command, item);
            if (row_typed) begin
                want.status     = row_status;
                want.occ        = row_occ;
                want.head_valid = (row_occ != 5'd0);
            end
            pending_views.push_back(want);
        end
    end

    // Drives one command beat at the falling edge and holds it until the
    // block takes it. Unless told to stay calm, the sender first drops
    // start about a third of the time.
    task automatic issue_command(input t_cmd_row row, input logic calm);
        int gap;
        if (!calm && $urandom_range(99) < 33) begin
            gap = $urandom_range(1);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_command      <= row.cmd;
        i_entry_id     <= row.id;
        i_priority_req <= row.prio;
        i_run_time     <= row.run;
        i_arrival_time <= row.arr;
        row_typed      <= row.typed;
        row_status     <= row.status;
        row_occ        <= row.occ;
        do @(posedge i_clk); while (busy);
    endtask

    // Random commands. Ids come mostly from a small pool so that duplicate
    // ids and hits on delete are common; half of the priorities come from a
    // narrow band so that ties are common. Full-range values make every
    // bit of every field toggle.
    function automatic t_cmd_row random_command(input int mode);
        t_cmd_row row;
        int       insert_pct;
        row.typed  = 1'b0;
        row.status = ST_OK;
        row.occ    = 5'd0;
        row.run    = 16'($urandom);
        row.arr    = 16'($urandom);
        row.id     = ($urandom_range(99) < 70) ? 16'($urandom_range(31)) : 16'($urandom);
        case ($urandom_range(3))
            0, 1:    row.prio = 16'($signed($urandom_range(6)) - 3);
            2:       row.prio = 16'($urandom);
            default: row.prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
        insert_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
        row.cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
        // Most deletes name an id that is actually held, so the gap-closing
        // path is exercised far more often than the not-found answer.
        if (row.cmd == CMD_DELETE && shadow_count > 0 && $urandom_range(99) < 85)
            row.id = shadow_store[$urandom_range(shadow_count - 1)].id;
        return row;
    endfunction

    initial begin
        int mode;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = CMD_INSERT;
        i_entry_id     = '0;
        i_priority_req = '0;
        i_run_time     = '0;
        i_arrival_time = '0;
        row_typed      = 1'b0;
        row_status     = ST_OK;
        row_occ        = '0;
        mode           = 2;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (cmd_table[n])
            issue_command(cmd_table[n], 1'b0);

        // The random part moves between filling, draining and balanced
        // stretches so that the queue keeps passing through empty and full.
        // Between items 400 and 560 the sender never idles.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 64 == 0)
                mode = $urandom_range(2);
            issue_command(random_command(mode), n >= 400 && n < 560);
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("[sorted_priority_queue] OK");
        else
            $display("[sorted_priority_queue] ERROR");
        $finish;
    end

    // A correct run needs well under ten microseconds; this guards a hang.
    initial begin
        #200000;
        $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/tb.sv
